@@ rtl/core/ook_pulse_width_bit_decoder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// OOK pulse width decoder assertion macros
// Clocked assertion helpers shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef OOK_PULSE_WIDTH_BIT_DECODER_UNIT_DEFINES_SVH
`define OOK_PULSE_WIDTH_BIT_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define OOKPW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ookpw: property violated");
`define OOKPW_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("ookpw: forbidden condition seen");
`else
`define OOKPW_ASSERT(lbl, prop)
`define OOKPW_NEVER(lbl, expr)
`endif

`endif

@@ rtl/core/ookpw_pkg.sv @@
// ----------------------------------------------------------------------------
// OOK pulse width decoder package
// Widths, register map, result codes and result type of the decoder.
// ----------------------------------------------------------------------------
package ookpw_pkg;

	localparam int RUN_BITS_DEF        = 16;
	localparam int MAX_SYMBOL_BITS_DEF = 128;

	localparam int GAP_W   = 4;
	localparam int MINB_W  = 7;
	localparam int CNT_W   = 7;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [GAP_W-1:0]  GAP_FACTOR_RST      = GAP_W'(4);
	localparam logic [MINB_W-1:0] MIN_SYMBOL_BITS_RST = MINB_W'(13);

	localparam logic REG_GAP_FACTOR      = 1'b0;
	localparam logic REG_MIN_SYMBOL_BITS = 1'b1;

	localparam logic KIND_BIT = 1'b0;
	localparam logic KIND_EOS = 1'b1;

	typedef struct packed {
		logic             kind;
		logic             bit_value;
		logic             low_duty;
		logic [CNT_W-1:0] bit_position;
		logic [CNT_W-1:0] symbol_length;
		logic             long_enough;
		logic             last;
	} result_t;

endpackage

@@ rtl/core/ookpw_sample_if.sv @@
// ----------------------------------------------------------------------------
// OOK sample channel
// Valid/ready channel carrying one demodulated carrier sample per beat.
// ----------------------------------------------------------------------------
interface ookpw_sample_if;
	logic valid;
	logic ready;
	logic sample_bit;

	modport source (output valid, output sample_bit, input ready);
	modport sink (input valid, input sample_bit, output ready);
endinterface

@@ rtl/core/ookpw_result_if.sv @@
// ----------------------------------------------------------------------------
// OOK result channel
// Valid/ready channel carrying one decoded bit or end of symbol per beat.
// ----------------------------------------------------------------------------
interface ookpw_result_if;
	import ookpw_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic             bit_value;
	logic             low_duty;
	logic [CNT_W-1:0] bit_position;
	logic [CNT_W-1:0] symbol_length;
	logic             long_enough;
	logic             last;

	modport source (
		output valid, output kind, output bit_value, output low_duty,
		output bit_position, output symbol_length, output long_enough, output last,
		input ready
	);
	modport sink (
		input valid, input kind, input bit_value, input low_duty,
		input bit_position, input symbol_length, input long_enough, input last,
		output ready
	);
endinterface

@@ rtl/core/ook_pulse_width_bit_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// OOK pulse width bit decoder
// Measures high and low runs of the carrier and decodes one bit per period.
// ----------------------------------------------------------------------------
// Path: an accepted sample beat is registered in the input stage, then its results enter the result queue.
// Throughput: one sample per cycle; the run update and bit decision fit in one
// stage, and a 4-entry result queue absorbs the extra end of symbol beat.
// Samples stall only while the queue has fewer than two free entries.
// Reset: arst_n clears runs, bit index, queue and stage valid, and loads
// gap_factor = 4 and min_symbol_bits = 13.
`include "ook_pulse_width_bit_decoder_unit_defines.svh"

module ook_pulse_width_bit_decoder_unit #(
	parameter int RUN_BITS        = ookpw_pkg::RUN_BITS_DEF,
	parameter int MAX_SYMBOL_BITS = ookpw_pkg::MAX_SYMBOL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ookpw_pkg::ADDR_W-1:0]  paddr,
	input  logic [ookpw_pkg::DATA_W-1:0]  pwdata,
	output logic [ookpw_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	ookpw_sample_if.sink                  sample,
	ookpw_result_if.source                result
);
	import ookpw_pkg::*;

	localparam int RUN_W      = RUN_BITS;
	localparam int LOW_W      = RUN_BITS + 4;
	localparam int CMP_W      = LOW_W + 2;
	localparam int IDX_W      = $clog2(MAX_SYMBOL_BITS);
	localparam int LEN_CMP_W  = (IDX_W > MINB_W) ? IDX_W : MINB_W;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	logic [GAP_W-1:0]  gap_factor_q;
	logic [MINB_W-1:0] min_symbol_bits_q;

	logic              valid_s1;
	logic              sample_s1;
	logic              adv;

	logic              counting_low_q;
	logic [RUN_W-1:0]  high_run_q;
	logic [LOW_W-1:0]  low_run_q;
	logic [IDX_W-1:0]  bit_idx_q;

	logic              counting_low_d;
	logic [RUN_W-1:0]  high_run_d;
	logic [LOW_W-1:0]  low_run_d;
	logic [IDX_W-1:0]  bit_idx_d;
	logic [IDX_W-1:0]  idx_inc;
	logic [LOW_W-1:0]  low_eff;
	logic [LOW_W-1:0]  gap_prod;
	logic [CMP_W-1:0]  high_x2;
	logic [CMP_W-1:0]  high_x4;
	logic [CMP_W-1:0]  low_x3;
	logic              chk;
	logic              tmo;
	logic [1:0]        n_push;
	result_t           res0;
	result_t           res1;

	result_t           fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic              pop;
	logic              cfg_wr;
	logic              reg_idx;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_factor_q      <= GAP_FACTOR_RST;
			min_symbol_bits_q <= MIN_SYMBOL_BITS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GAP_FACTOR:      gap_factor_q      <= pwdata[GAP_W-1:0];
				REG_MIN_SYMBOL_BITS: min_symbol_bits_q <= pwdata[MINB_W-1:0];
				default:             gap_factor_q      <= gap_factor_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GAP_FACTOR:      prdata = DATA_W'(gap_factor_q);
			REG_MIN_SYMBOL_BITS: prdata = DATA_W'(min_symbol_bits_q);
			default:             prdata = '0;
		endcase
	end

	// input stage
	assign adv          = valid_s1 && (count_q <= FCNT_W'(FIFO_DEPTH - 2));
	assign sample.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample.sample_bit;
		end
	end

	// run measurement and bit decision
	always_comb begin
		if (!counting_low_q) begin
			low_eff = LOW_W'(1);
		end else if (sample_s1 || (low_run_q == '1)) begin
			low_eff = low_run_q;
		end else begin
			low_eff = low_run_q + 1'b1;
		end

		gap_prod = LOW_W'(gap_factor_q) * LOW_W'(high_run_q);
		high_x2  = CMP_W'(high_run_q) << 1;
		high_x4  = CMP_W'(high_run_q) << 2;
		low_x3   = CMP_W'(low_eff) + (CMP_W'(low_eff) << 1);
		idx_inc  = (bit_idx_q == IDX_W'(MAX_SYMBOL_BITS - 1)) ? '0 : bit_idx_q + 1'b1;

		res0.kind          = KIND_BIT;
		res0.bit_value     = high_x2 > low_x3;
		res0.low_duty      = high_x4 <= CMP_W'(low_eff);
		res0.bit_position  = CNT_W'(bit_idx_q);
		res0.symbol_length = '0;
		res0.long_enough   = 1'b0;
		res0.last          = 1'b0;

		res1.kind          = KIND_EOS;
		res1.bit_value     = 1'b0;
		res1.low_duty      = 1'b0;
		res1.bit_position  = '0;
		res1.symbol_length = CNT_W'(idx_inc);
		res1.long_enough   = LEN_CMP_W'(idx_inc) > LEN_CMP_W'(min_symbol_bits_q);
		res1.last          = 1'b1;

		counting_low_d = counting_low_q;
		high_run_d     = high_run_q;
		low_run_d      = low_run_q;
		bit_idx_d      = bit_idx_q;
		n_push         = 2'd0;
		chk            = 1'b0;
		tmo            = 1'b0;

		if (!counting_low_q) begin
			if (sample_s1) begin
				if (high_run_q != '1) begin
					high_run_d = high_run_q + 1'b1;
				end
			end else if (high_run_q != '0) begin
				chk = 1'b1;
			end
		end else if (sample_s1) begin
			n_push         = 2'd1;
			res0.last      = 1'b1;
			counting_low_d = 1'b0;
			high_run_d     = RUN_W'(1);
			low_run_d      = '0;
			bit_idx_d      = idx_inc;
		end else begin
			chk = 1'b1;
		end

		if (chk) begin
			if (low_eff > gap_prod) begin
				tmo            = 1'b1;
				n_push         = 2'd2;
				counting_low_d = 1'b0;
				high_run_d     = '0;
				low_run_d      = '0;
				bit_idx_d      = '0;
			end else begin
				counting_low_d = 1'b1;
				low_run_d      = low_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counting_low_q <= 1'b0;
			high_run_q     <= '0;
			low_run_q      <= '0;
			bit_idx_q      <= '0;
		end else if (adv) begin
			counting_low_q <= counting_low_d;
			high_run_q     <= high_run_d;
			low_run_q      <= low_run_d;
			bit_idx_q      <= bit_idx_d;
		end
	end

	// result queue
	assign pop = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (adv ? FCNT_W'(n_push) : '0) - FCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (n_push != 2'd0)) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (adv && (n_push == 2'd2)) begin
			fifo_q[wr_ptr_q + 1'b1] <= res1;
		end
	end

	assign result.valid         = count_q != '0;
	assign result.kind          = fifo_q[rd_ptr_q].kind;
	assign result.bit_value     = fifo_q[rd_ptr_q].bit_value;
	assign result.low_duty      = fifo_q[rd_ptr_q].low_duty;
	assign result.bit_position  = fifo_q[rd_ptr_q].bit_position;
	assign result.symbol_length = fifo_q[rd_ptr_q].symbol_length;
	assign result.long_enough   = fifo_q[rd_ptr_q].long_enough;
	assign result.last          = fifo_q[rd_ptr_q].last;

	`OOKPW_NEVER(a_queue_overflow, count_q > FCNT_W'(FIFO_DEPTH))
	`OOKPW_NEVER(a_low_without_high, counting_low_q && (high_run_q == '0))
	`OOKPW_ASSERT(a_timeout_rearm, adv && tmo |=> !counting_low_q && (high_run_q == '0))
	`OOKPW_ASSERT(a_eos_is_last, result.valid && (result.kind == KIND_EOS) |-> result.last)
	`OOKPW_ASSERT(a_stall_when_full, (count_q > FCNT_W'(FIFO_DEPTH - 2)) |-> !adv)

endmodule
